FILE: hdl/ptss_pkg.sv
// Shared types and constants for the polygon triangle strip stitcher.
// Used by ptss_ctrl, ptss_dp and polygon_triangle_strip_stitcher; no dependencies.
package ptss_pkg;

	localparam int INDEX_BITS     = 16;
	localparam int MAX_POLY_VERTS = 62;
	localparam int MIN_POLY_VERTS = 3;
	localparam int CNT_W          = 6;   // width of the vertex count field
	localparam int OUT_IDX_W      = 16;  // width of the emitted index field

	typedef logic [INDEX_BITS-1:0] idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	// which index source the datapath puts on the output word
	typedef enum logic [1:0] {
		SEL_PREV = 2'd0,
		SEL_BASE = 2'd1,
		SEL_VERT = 2'd2
	} sel_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PREV = 4'b0010,
		S_BASE = 4'b0100,
		S_VERT = 4'b1000
	} state_t;

	typedef struct packed {
		logic load;   // take the input polygon
		logic emit;   // write one word into the output register
		sel_t sel;
	} cmd_t;

	typedef struct packed {
		logic item_ok;        // vertex count is at least three
		logic stitch_needed;  // a section is open for the input polygon
		logic last_vert;      // one vertex left to emit
	} status_t;

endpackage

FILE: hdl/polygon_triangle_strip_stitcher.sv
// Top level of the polygon triangle strip stitcher: stream ports, controller
// and datapath. Depends on ptss_pkg, ptss_ctrl and ptss_dp.
//
// Takes one convex polygon per input word and emits its triangle strip indices,
// one index per output word: two degenerate stitch indices (last index, new
// base) when the polygon continues an open section, then n vertices in zigzag
// order (n is clamped to 62; counts below 3 are consumed with no output).
// The output register emits at most one index per cycle; the controller takes
// the next polygon once the last index is in the output register. tlast marks
// the final index of each polygon.
module polygon_triangle_strip_stitcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [5:0] vertex_count, [7:6] zero
	input  logic [1:0]  s_axis_tuser,   // [0] starts_section, [1] starts_mesh
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] strip_index
	output logic [1:0]  m_axis_tuser,   // [0] is_stitch, [1] base_wrapped
	output logic        m_axis_tlast    // last_of_polygon
);

	ptss_pkg::cmd_t    cmd;
	ptss_pkg::status_t st;

	ptss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.st        (st),
		.cmd       (cmd)
	);

	ptss_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.vertex_count    (s_axis_tdata[ptss_pkg::CNT_W-1:0]),
		.starts_section  (s_axis_tuser[0]),
		.starts_mesh     (s_axis_tuser[1]),
		.cmd             (cmd),
		.st              (st),
		.strip_index     (m_axis_tdata),
		.is_stitch       (m_axis_tuser[0]),
		.base_wrapped    (m_axis_tuser[1]),
		.last_of_polygon (m_axis_tlast)
	);

endmodule

FILE: hdl/ptss_ctrl.sv
// Controller of the strip stitcher: sequences stitch words and vertex words
// and owns the output valid flag. Depends on ptss_pkg.
module ptss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ptss_pkg::status_t st,
	output ptss_pkg::cmd_t    cmd
);

	ptss_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             can_emit;

	assign in_ready  = (state_q == ptss_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign can_emit  = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.emit = 1'b0;
		cmd.sel  = ptss_pkg::SEL_VERT;
		case (state_q)
			ptss_pkg::S_IDLE: begin
				if (in_valid && st.item_ok) begin
					cmd.load = 1'b1;
					state_d  = st.stitch_needed ? ptss_pkg::S_PREV : ptss_pkg::S_VERT;
				end
			end
			ptss_pkg::S_PREV: begin
				cmd.sel  = ptss_pkg::SEL_PREV;
				cmd.emit = can_emit;
				if (can_emit) state_d = ptss_pkg::S_BASE;
			end
			ptss_pkg::S_BASE: begin
				cmd.sel  = ptss_pkg::SEL_BASE;
				cmd.emit = can_emit;
				if (can_emit) state_d = ptss_pkg::S_VERT;
			end
			ptss_pkg::S_VERT: begin
				cmd.emit = can_emit;
				if (can_emit && st.last_vert) state_d = ptss_pkg::S_IDLE;
			end
			default: state_d = ptss_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptss_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_item_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && st.item_ok |=> state_q != ptss_pkg::S_IDLE)
		else $error("accepted polygon did not start emission");

	a_base_after_prev: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ptss_pkg::S_BASE |->
			$past(state_q) == ptss_pkg::S_PREV || $past(state_q) == ptss_pkg::S_BASE)
		else $error("base stitch without previous stitch");

	a_last_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ptss_pkg::S_VERT && cmd.emit && st.last_vert
			|=> state_q == ptss_pkg::S_IDLE)
		else $error("polygon end did not return to idle");

endmodule

FILE: hdl/ptss_dp.sv
// Datapath of the strip stitcher: running base, last index, parity, zigzag
// low/high index counters and the output word register. Depends on ptss_pkg.
module ptss_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ptss_pkg::cnt_t                  vertex_count,
	input  logic                            starts_section,
	input  logic                            starts_mesh,
	input  ptss_pkg::cmd_t                  cmd,
	output ptss_pkg::status_t               st,
	output logic [ptss_pkg::OUT_IDX_W-1:0]  strip_index,
	output logic                            is_stitch,
	output logic                            base_wrapped,
	output logic                            last_of_polygon
);

	localparam int IW = ptss_pkg::INDEX_BITS;

	// persistent state
	ptss_pkg::idx_t vertex_base_q, prev_q;
	logic           strip_parity_q, section_open_q;

	// per-polygon work registers
	ptss_pkg::idx_t base_q, lo_q, hi_q;
	ptss_pkg::cnt_t rem_q;
	logic           first_q, take_lo_q, wrapped_q;

	// output word
	logic [ptss_pkg::OUT_IDX_W-1:0] strip_index_q;
	logic                           is_stitch_q, last_q, base_wrapped_q;

	ptss_pkg::cnt_t n_sat;
	ptss_pkg::idx_t base_in, vert_idx, emit_idx;
	logic           eff_parity;
	logic [IW:0]    base_sum;

	assign n_sat = (vertex_count > ptss_pkg::cnt_t'(ptss_pkg::MAX_POLY_VERTS))
		? ptss_pkg::cnt_t'(ptss_pkg::MAX_POLY_VERTS) : vertex_count;
	assign base_in    = starts_mesh ? '0 : vertex_base_q;
	assign eff_parity = strip_parity_q & ~starts_section;
	assign base_sum   = {1'b0, base_in} + (IW+1)'(n_sat);

	assign st.item_ok       = vertex_count >= ptss_pkg::cnt_t'(ptss_pkg::MIN_POLY_VERTS);
	assign st.stitch_needed = section_open_q & ~starts_section;
	assign st.last_vert     = (rem_q == ptss_pkg::cnt_t'(1));

	assign vert_idx = first_q ? base_q : (take_lo_q ? lo_q : hi_q);

	always_comb begin
		case (cmd.sel)
			ptss_pkg::SEL_PREV: emit_idx = prev_q;
			ptss_pkg::SEL_BASE: emit_idx = base_q;
			ptss_pkg::SEL_VERT: emit_idx = vert_idx;
			default:            emit_idx = vert_idx;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_base_q  <= '0;
			prev_q         <= '0;
			strip_parity_q <= 1'b0;
			section_open_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				vertex_base_q  <= base_sum[IW-1:0];
				strip_parity_q <= eff_parity ^ n_sat[0];
				section_open_q <= 1'b1;
			end
			if (cmd.emit && cmd.sel == ptss_pkg::SEL_VERT) prev_q <= vert_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q    <= base_in;
			lo_q      <= base_in + ptss_pkg::idx_t'(1);
			hi_q      <= base_sum[IW-1:0] - ptss_pkg::idx_t'(1);
			rem_q     <= n_sat;
			first_q   <= 1'b1;
			take_lo_q <= ~eff_parity;
			wrapped_q <= base_sum[IW];
		end else if (cmd.emit && cmd.sel == ptss_pkg::SEL_VERT) begin
			rem_q   <= rem_q - ptss_pkg::cnt_t'(1);
			first_q <= 1'b0;
			if (!first_q) begin
				// zigzag: alternate between the low and high ends
				if (take_lo_q) lo_q <= lo_q + ptss_pkg::idx_t'(1);
				else           hi_q <= hi_q - ptss_pkg::idx_t'(1);
				take_lo_q <= ~take_lo_q;
			end
		end
		if (cmd.emit) begin
			strip_index_q  <= ptss_pkg::OUT_IDX_W'(emit_idx);
			is_stitch_q    <= (cmd.sel != ptss_pkg::SEL_VERT);
			base_wrapped_q <= wrapped_q;
			last_q         <= (cmd.sel == ptss_pkg::SEL_VERT) && st.last_vert;
		end
	end

	assign strip_index     = strip_index_q;
	assign is_stitch       = is_stitch_q;
	assign base_wrapped    = base_wrapped_q;
	assign last_of_polygon = last_q;

	a_zigzag_meets: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && cmd.sel == ptss_pkg::SEL_VERT && st.last_vert && !first_q
			|-> lo_q == hi_q)
		else $error("zigzag ends did not meet on last vertex");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for polygon_triangle_strip_stitcher: stream stimulus,
// a strip index predictor and a per-field word checker. Depends on ptss_pkg and the RTL.
module testbench;

	typedef struct packed {
		ptss_pkg::idx_t index;
		logic           stitch;
		logic           wrapped;
		logic           last;
	} strip_word_t;

	// directed polygons; expected word count, first index and stitch flag where obvious
	typedef struct packed {
		ptss_pkg::cnt_t cnt;
		logic           sec;
		logic           mesh;
		logic           known;
		logic [7:0]     words;
		ptss_pkg::idx_t first;
		logic           stitch;
	} poly_row_t;

	localparam int N_DIRECTED = 20;
	localparam poly_row_t DIRECTED [N_DIRECTED] = '{
		'{6'd3,  1'b0, 1'b0, 1'b1, 8'd3,  16'd0,  1'b0},  // first after reset, no stitch
		'{6'd0,  1'b1, 1'b1, 1'b1, 8'd0,  16'd0,  1'b0},  // too few vertices: dropped
		'{6'd1,  1'b1, 1'b0, 1'b1, 8'd0,  16'd0,  1'b0},
		'{6'd2,  1'b0, 1'b1, 1'b1, 8'd0,  16'd0,  1'b0},
		'{6'd4,  1'b0, 1'b0, 1'b1, 8'd6,  16'd2,  1'b1},  // stitch, flipped order
		'{6'd63, 1'b0, 1'b0, 1'b1, 8'd64, 16'd5,  1'b1},  // saturates to 62
		'{6'd62, 1'b1, 1'b0, 1'b1, 8'd62, 16'd69, 1'b0},
		'{6'd5,  1'b0, 1'b1, 1'b0, 8'd0,  16'd0,  1'b0},  // new mesh, open section
		'{6'd7,  1'b1, 1'b1, 1'b1, 8'd7,  16'd0,  1'b0},
		'{6'd3,  1'b0, 1'b0, 1'b0, 8'd0,  16'd0,  1'b0},
		'{6'd6,  1'b1, 1'b0, 1'b0, 8'd0,  16'd0,  1'b0},
		'{6'd32, 1'b0, 1'b0, 1'b0, 8'd0,  16'd0,  1'b0},
		'{6'd16, 1'b0, 1'b1, 1'b0, 8'd0,  16'd0,  1'b0},
		'{6'd8,  1'b1, 1'b0, 1'b0, 8'd0,  16'd0,  1'b0},
		'{6'd63, 1'b1, 1'b1, 1'b1, 8'd62, 16'd0,  1'b0},
		'{6'd9,  1'b0, 1'b0, 1'b0, 8'd0,  16'd0,  1'b0},
		'{6'd62, 1'b0, 1'b0, 1'b0, 8'd0,  16'd0,  1'b0},
		'{6'd3,  1'b1, 1'b0, 1'b0, 8'd0,  16'd0,  1'b0},
		'{6'd11, 1'b0, 1'b0, 1'b0, 8'd0,  16'd0,  1'b0},
		'{6'd21, 1'b0, 1'b1, 1'b0, 8'd0,  16'd0,  1'b0}
	};

	localparam int N_RANDOM = 310;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// predictor state
	ptss_pkg::idx_t next_base;
	ptss_pkg::idx_t last_index;
	logic odd_strip;
	logic in_section;
	strip_word_t pending_indices [$];
	strip_word_t first_word;

	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;
	int polys_taken;
	int words_checked;
	int wrapped_polys;
	int stitch_words;

	polygon_triangle_strip_stitcher dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("t=%0t %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	// Queues the strip words one polygon produces and advances the strip state.
	function automatic int strip_indices_for(input ptss_pkg::cnt_t cnt, input logic sec,
		input logic mesh);
		int unsigned    n;
		int unsigned    off;
		ptss_pkg::idx_t b;
		logic           wrap;
		logic           flip;
		int             words;
		strip_word_t    w;
		words = 0;
		if (cnt < ptss_pkg::MIN_POLY_VERTS)
			return 0;
		n = (cnt > ptss_pkg::MAX_POLY_VERTS) ? ptss_pkg::MAX_POLY_VERTS : cnt;
		if (mesh)
			next_base = '0;
		if (sec) begin
			in_section = 1'b0;
			odd_strip  = 1'b0;
		end
		b    = next_base;
		wrap = (longint'(b) + n) >= (longint'(1) << ptss_pkg::INDEX_BITS);
		if (wrap)
			wrapped_polys++;
		if (in_section) begin
			w = '{last_index, 1'b1, wrap, 1'b0};
			pending_indices = {pending_indices, w};
			first_word = w;
			w = '{b, 1'b1, wrap, 1'b0};
			pending_indices = {pending_indices, w};
			words = 2;
		end
		flip = odd_strip;
		for (int unsigned i = 0; i < n; i++) begin
			if (i == 0)
				off = 0;
			else if (flip)
				off = (i % 2 == 0) ? i / 2 : n - (i + 1) / 2;
			else
				off = (i % 2 == 0) ? n - i / 2 : i / 2 + 1;
			last_index = ptss_pkg::idx_t'(b + off);
			w = '{last_index, 1'b0, wrap, i == n - 1};
			pending_indices = {pending_indices, w};
			if (words == 0)
				first_word = w;
			words++;
		end
		odd_strip  = odd_strip ^ n[0];
		in_section = 1'b1;
		next_base  = ptss_pkg::idx_t'(b + n);
		return words;
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_polygon(input ptss_pkg::cnt_t cnt, input logic sec, input logic mesh,
		output int words, output strip_word_t first);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, cnt};
		s_axis_tuser  <= {mesh, sec};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		words = strip_indices_for(cnt, sec, mesh);
		first = first_word;
		if (words > 0)
			polys_taken++;
		@(negedge clk);
	endtask

	task automatic send_random_polygon(output int words);
		ptss_pkg::cnt_t cnt;
		strip_word_t    first;
		int             pick;
		pick = $urandom_range(99);
		if (pick < 6)
			cnt = ptss_pkg::cnt_t'($urandom_range(2));
		else if (pick < 14)
			cnt = 6'd63;
		else if (pick < 30)
			cnt = ptss_pkg::cnt_t'($urandom_range(40, 62));
		else
			cnt = ptss_pkg::cnt_t'($urandom_range(3, 20));
		send_polygon(cnt, $urandom_range(3) == 0, $urandom_range(7) == 0, words, first);
	endtask

	// receiver back-pressure
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		strip_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_indices.size() == 0) begin
				report_mismatch("unexpected word, strip_index", m_axis_tdata, 0);
			end else begin
				want = pending_indices.pop_front();
				if (m_axis_tdata !== want.index)
					report_mismatch("strip_index", m_axis_tdata, want.index);
				if (m_axis_tuser[0] !== want.stitch)
					report_mismatch("is_stitch", m_axis_tuser[0], want.stitch);
				if (m_axis_tuser[1] !== want.wrapped)
					report_mismatch("base_wrapped", m_axis_tuser[1], want.wrapped);
				if (m_axis_tlast !== want.last)
					report_mismatch("last_of_polygon", m_axis_tlast, want.last);
				if (want.stitch)
					stitch_words++;
				words_checked++;
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int          words;
		int          taken;
		strip_word_t first;
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		next_base      = '0;
		last_index     = '0;
		odd_strip      = 1'b0;
		in_section     = 1'b0;
		mismatches     = 0;
		polys_taken    = 0;
		words_checked  = 0;
		wrapped_polys  = 0;
		stitch_words   = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int r = 0; r < N_DIRECTED; r++) begin
			send_polygon(DIRECTED[r].cnt, DIRECTED[r].sec, DIRECTED[r].mesh, words, first);
			if (DIRECTED[r].known) begin
				if (words != DIRECTED[r].words)
					report_mismatch($sformatf("row %0d word count", r), words,
						DIRECTED[r].words);
				if (words > 0 && first.index !== DIRECTED[r].first)
					report_mismatch($sformatf("row %0d first index", r), first.index,
						DIRECTED[r].first);
				if (words > 0 && first.stitch !== DIRECTED[r].stitch)
					report_mismatch($sformatf("row %0d first stitch", r), first.stitch,
						DIRECTED[r].stitch);
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			taken = 0;
			while (taken < N_RANDOM / 4 + 1) begin
				send_random_polygon(words);
				taken++;
			end
		end
		s_axis_tvalid <= 1'b0;

		while (pending_indices.size() != 0)
			@(posedge clk);
		repeat (70) @(posedge clk);
		if (pending_indices.size() != 0)
			report_mismatch("words never delivered", pending_indices.size(), 0);

		$display("Covered %0d polygons, %0d strip words (%0d stitch), %0d wrapping polygons,",
			polys_taken, words_checked, stitch_words, wrapped_polys);
		$display("under no idling, sender gaps, receiver stalls and both together.");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
